// ===== rtl/swg_pkg.sv =====
// ----------------------------------------------------------------------------
// swg_pkg: shared types and constants for the epsilon-greedy arm selector
// Holds the command codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package swg_pkg;

  localparam int MAX_ARMS_DEF     = 16;
  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int REWARD_BITS_DEF  = 16;

  localparam int EPS_W  = 17;
  localparam int ARMC_W = 5;
  localparam int WLEN_W = 7;
  localparam int CFG_W  = 17;
  localparam int SUM_W  = 22;
  localparam int HITS_W = 7;
  localparam int ARM_W  = 4;
  localparam int RAND_W = 16;

  localparam logic [EPS_W-1:0]  EPS_RST  = 17'd6554;
  localparam logic [ARMC_W-1:0] ARMC_RST = 5'd16;
  localparam logic [WLEN_W-1:0] WLEN_RST = 7'd64;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_SELECT = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_EPSILON   = 2'd0,
    CFG_ARM_COUNT = 2'd1,
    CFG_WIN_LEN   = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_EVICT_RD,
    ST_EVICT,
    ST_PUSH,
    ST_SCAN,
    ST_SCAN_CMP,
    ST_DONE,
    ST_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic latch;      // capture input item
    logic clr_step;   // clear one arm statistic
    logic clr_start;  // reset clear counter, head, fill, warm-up
    logic evict_rd;   // issue window read for the oldest entry
    logic evict;      // subtract evicted entry
    logic push;       // append new entry
    logic decide;     // warm-up / explore decision
    logic scan_start; // start argmax
    logic scan_step;  // load one arm into compare stage
    logic scan_cmp;   // compare loaded arm with best
    logic query;      // load query result
    logic pick_best;  // load argmax result
  } swg_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       clr_last;
    logic       arm_ok;
    logic       full;
    logic       exploit;
    logic       scan_last;
  } swg_sts_t;

endpackage

// ===== rtl/swg_ram.sv =====
// ----------------------------------------------------------------------------
// swg_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module swg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/swg_ctrl.sv =====
// ----------------------------------------------------------------------------
// swg_ctrl: controller state machine
// Sequences clear, evict/push, warm-up/explore decision and the argmax scan.
// ----------------------------------------------------------------------------
module swg_ctrl
  import swg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  logic     cfg_clear,
  input  swg_sts_t sts,
  output swg_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else if (cfg_clear) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Item latched; dispatch on its command.
        case (sts.cmd)
          CMD_UPDATE: state_nxt = !sts.arm_ok ? ST_IDLE :
                                  (sts.full ? ST_EVICT_RD : ST_PUSH);
          CMD_CLEAR:  state_nxt = ST_CLEAR;
          CMD_QUERY:  state_nxt = ST_OUT;
          default:    state_nxt = sts.exploit ? ST_SCAN : ST_OUT;
        endcase
      end
      ST_CLEAR:    state_nxt = sts.clr_last ? ST_IDLE : ST_CLEAR;
      ST_EVICT_RD: state_nxt = ST_EVICT;
      ST_EVICT:    state_nxt = ST_PUSH;
      ST_PUSH:     state_nxt = ST_IDLE;
      ST_SCAN:     state_nxt = ST_SCAN_CMP;
      ST_SCAN_CMP: state_nxt = sts.scan_last ? ST_OUT : ST_SCAN;
      ST_OUT:      state_nxt = out_stall ? ST_OUT : ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
      end
      ST_DONE: begin
        cmd.clr_start  = (sts.cmd == CMD_CLEAR);
        cmd.decide     = (sts.cmd == CMD_SELECT);
        cmd.query      = (sts.cmd == CMD_QUERY);
        cmd.scan_start = (sts.cmd == CMD_SELECT) && sts.exploit;
        cmd.evict_rd   = (sts.cmd == CMD_UPDATE) && sts.arm_ok && sts.full;
      end
      ST_CLEAR:    cmd.clr_step = 1'b1;
      ST_EVICT:    cmd.evict = 1'b1;
      ST_PUSH:     cmd.push = 1'b1;
      ST_SCAN:     cmd.scan_step = 1'b1;
      ST_SCAN_CMP: begin
        cmd.scan_cmp  = 1'b1;
        cmd.pick_best = sts.scan_last;
      end
      ST_OUT:      out_valid = 1'b1;
      default:     cmd = '0;
    endcase
  end

endmodule

// ===== rtl/swg_dp.sv =====
// ----------------------------------------------------------------------------
// swg_dp: datapath of the epsilon-greedy arm selector
// Window ring in RAM, per-arm sums and counts, argmax compare stage.
// ----------------------------------------------------------------------------
module swg_dp
  import swg_pkg::*;
#(
  parameter int MAX_ARMS     = MAX_ARMS_DEF,
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int REWARD_BITS  = REWARD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  swg_cmd_t               cmd,
  output swg_sts_t               sts,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic [1:0]             in_command,
  input  logic [REWARD_BITS-1:0] in_reward,
  input  logic [ARM_W-1:0]       in_arm,
  input  logic [RAND_W-1:0]      in_rand_uniform,
  input  logic [ARM_W-1:0]       in_rand_arm,
  output logic [ARM_W-1:0]       out_chosen_arm,
  output logic [SUM_W-1:0]       out_arm_sum,
  output logic [HITS_W-1:0]      out_arm_hits,
  output logic                   out_explored
);

  localparam int AI_W  = $clog2(MAX_ARMS);
  localparam int AN_W  = $clog2(MAX_ARMS + 1);
  localparam int WA_W  = $clog2(WINDOW_DEPTH);
  localparam int WF_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int ENT_W = REWARD_BITS + AI_W;
  localparam int PR_W  = SUM_W + HITS_W;

  // Configuration registers.
  logic [EPS_W-1:0]  eps_r;
  logic [ARMC_W-1:0] armc_r;
  logic [WLEN_W-1:0] wlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r  <= EPS_RST;
      armc_r <= ARMC_RST;
      wlen_r <= WLEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EPSILON:   eps_r  <= cfg_wdata[EPS_W-1:0];
        CFG_ARM_COUNT: armc_r <= cfg_wdata[ARMC_W-1:0];
        CFG_WIN_LEN:   wlen_r <= cfg_wdata[WLEN_W-1:0];
        default:       eps_r  <= eps_r;
      endcase
    end
  end

  // Effective arm count and capacity after clamping.
  logic [AN_W-1:0] n_arms;
  logic [WF_W-1:0] cap;
  always_comb begin
    if (armc_r == '0) begin
      n_arms = AN_W'(1);
    end else if (32'(armc_r) > MAX_ARMS) begin
      n_arms = AN_W'(MAX_ARMS);
    end else begin
      n_arms = AN_W'(armc_r);
    end
    if (wlen_r == '0) begin
      cap = WF_W'(1);
    end else if (32'(wlen_r) > WINDOW_DEPTH) begin
      cap = WF_W'(WINDOW_DEPTH);
    end else begin
      cap = WF_W'(wlen_r);
    end
  end

  // Latched input item.
  logic [1:0]             cmd_r;
  logic [REWARD_BITS-1:0] rew_r;
  logic [ARM_W-1:0]       arm_r;
  logic [RAND_W-1:0]      ru_r;
  logic [ARM_W-1:0]       ra_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= in_command;
      rew_r <= in_reward;
      arm_r <= in_arm;
      ru_r  <= in_rand_uniform;
      ra_r  <= in_rand_arm;
    end
  end

  // Per-arm statistics, one register per arm.
  logic [SUM_W-1:0]  sum_r [MAX_ARMS];
  logic [HITS_W-1:0] cnt_r [MAX_ARMS];
  logic [AN_W-1:0]   clr_r;
  logic [WA_W-1:0]   head_r;
  logic [WF_W-1:0]   fill_r;
  logic [AN_W-1:0]   warm_r;

  logic [ENT_W-1:0] ev_data;
  logic [AI_W-1:0]  ev_arm;
  logic [REWARD_BITS-1:0] ev_rew;
  logic [AI_W-1:0]  new_arm;
  logic [WA_W-1:0]  old_addr;

  assign ev_arm   = ev_data[ENT_W-1:REWARD_BITS];
  assign ev_rew   = ev_data[REWARD_BITS-1:0];
  assign new_arm  = AI_W'(arm_r);
  assign old_addr = head_r - WA_W'(fill_r);

  swg_ram #(.WIDTH(ENT_W), .DEPTH(WINDOW_DEPTH)) u_win (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (head_r),
    .wdata ({new_arm, rew_r}),
    .raddr (old_addr),
    .rdata (ev_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      head_r <= '0;
      fill_r <= '0;
      warm_r <= '0;
    end else if (cmd.clr_start || (cfg_we && (cfg_index == CFG_ARM_COUNT ||
                                              cfg_index == CFG_WIN_LEN))) begin
      clr_r  <= '0;
      head_r <= '0;
      fill_r <= '0;
      warm_r <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.evict) begin
        fill_r <= fill_r - 1'b1;
      end else if (cmd.push) begin
        head_r <= head_r + 1'b1;
        fill_r <= fill_r + 1'b1;
      end
      if (cmd.decide && warm_r < n_arms) begin
        warm_r <= warm_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      sum_r[clr_r[AI_W-1:0]] <= '0;
      cnt_r[clr_r[AI_W-1:0]] <= '0;
    end else if (cmd.evict) begin
      sum_r[ev_arm] <= (sum_r[ev_arm] >= SUM_W'(ev_rew)) ?
                       sum_r[ev_arm] - SUM_W'(ev_rew) : '0;
      if (cnt_r[ev_arm] != '0) begin
        cnt_r[ev_arm] <= cnt_r[ev_arm] - 1'b1;
      end
    end else if (cmd.push) begin
      sum_r[new_arm] <= sum_r[new_arm] + SUM_W'(rew_r);
      cnt_r[new_arm] <= cnt_r[new_arm] + 1'b1;
    end
  end

  // Argmax scan: one arm after another, products registered before compare.
  logic [AN_W-1:0]  idx_r;
  logic [AI_W-1:0]  best_r;
  logic [SUM_W-1:0] bsum_r;
  logic [HITS_W-1:0] bcnt_r;
  logic [PR_W-1:0]  pi_r, pb_r;
  logic [HITS_W-1:0] ci, cb;
  logic [AI_W-1:0]  idx_a;

  assign idx_a = idx_r[AI_W-1:0];
  assign ci = (cnt_r[idx_a] == '0) ? HITS_W'(1) : cnt_r[idx_a];
  assign cb = (bcnt_r == '0) ? HITS_W'(1) : bcnt_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx_r  <= AN_W'(1);
      best_r <= '0;
      bsum_r <= sum_r[0];
      bcnt_r <= cnt_r[0];
    end else if (cmd.scan_step) begin
      pi_r <= PR_W'(sum_r[idx_a]) * PR_W'(cb);
      pb_r <= PR_W'(bsum_r) * PR_W'(ci);
    end else if (cmd.scan_cmp) begin
      if (idx_r < n_arms && pi_r > pb_r) begin
        best_r <= idx_a;
        bsum_r <= sum_r[idx_a];
        bcnt_r <= cnt_r[idx_a];
      end
      idx_r <= idx_r + 1'b1;
    end
  end

  logic scan_last;
  assign scan_last = (idx_r + 1'b1 >= n_arms);

  logic explore;
  assign explore = ({1'b0, ru_r} < eps_r);

  // Result register.
  logic [ARM_W-1:0]  o_arm_r;
  logic [SUM_W-1:0]  o_sum_r;
  logic [HITS_W-1:0] o_hits_r;
  logic              o_expl_r;
  logic [AI_W-1:0]   q_arm;
  logic [AN_W-1:0]   ra_clamp;

  assign q_arm    = AI_W'(arm_r);
  assign ra_clamp = (AN_W'(ra_r) < n_arms) ? AN_W'(ra_r) : n_arms - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.query) begin
      o_arm_r  <= '0;
      o_sum_r  <= sum_r[q_arm];
      o_hits_r <= cnt_r[q_arm];
      o_expl_r <= 1'b0;
    end else if (cmd.decide) begin
      o_sum_r  <= '0;
      o_hits_r <= '0;
      o_expl_r <= 1'b0;
      if (warm_r < n_arms) begin
        o_arm_r <= ARM_W'(warm_r);
      end else if (explore) begin
        o_arm_r  <= ARM_W'(ra_clamp);
        o_expl_r <= 1'b1;
      end else begin
        o_arm_r <= '0;
      end
    end else if (cmd.pick_best) begin
      o_arm_r <= (idx_r < n_arms && pi_r > pb_r) ? ARM_W'(idx_a) : ARM_W'(best_r);
    end
  end

  assign out_chosen_arm = o_arm_r;
  assign out_arm_sum    = o_sum_r;
  assign out_arm_hits   = o_hits_r;
  assign out_explored   = o_expl_r;

  assign sts.cmd       = cmd_r;
  assign sts.clr_last  = (clr_r == AN_W'(MAX_ARMS - 1));
  assign sts.arm_ok    = (AN_W'(arm_r) < n_arms) && (32'(arm_r) < MAX_ARMS);
  assign sts.full      = (fill_r >= cap);
  assign sts.exploit   = (warm_r >= n_arms) && !explore && (n_arms > AN_W'(1));
  assign sts.scan_last = scan_last;

endmodule

// ===== rtl/sliding_window_epsilon_greedy_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_window_epsilon_greedy_unit: epsilon-greedy arm selector
// Sliding reward window with per-arm sums and counts; select, query, clear.
// ----------------------------------------------------------------------------
// One item is worked on at a time. An update passes through the push state,
// and first through the evict-read and evict states when the window is full
// and the oldest entry is read back from the window RAM and evicted; an update
// for an arm not in use is dropped after the dispatch state. A query, a warm-up
// select and an explore select go from dispatch straight to the result transfer.
// An exploit select walks the arms after the first through one shared
// multiply-and-compare stage, loading and then comparing each arm. A result is
// held while out_stall is high. A clear command, a write of arm_count or
// window_length, and reset start a clearing pass over the statistics of all
// MAX_ARMS arms, during which no item is accepted.
module sliding_window_epsilon_greedy_unit
  import swg_pkg::*;
#(
  parameter int MAX_ARMS     = MAX_ARMS_DEF,
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int REWARD_BITS  = REWARD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_command,
  input  logic [REWARD_BITS-1:0] in_reward,
  input  logic [ARM_W-1:0]       in_arm,
  input  logic [RAND_W-1:0]      in_rand_uniform,
  input  logic [ARM_W-1:0]       in_rand_arm,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [ARM_W-1:0]       out_chosen_arm,
  output logic [SUM_W-1:0]       out_arm_sum,
  output logic [HITS_W-1:0]      out_arm_hits,
  output logic                   out_explored
);

  swg_cmd_t cmd;
  swg_sts_t sts;
  logic     cfg_clear;

  assign cfg_clear = cfg_we && (cfg_index == CFG_ARM_COUNT || cfg_index == CFG_WIN_LEN);

  swg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_clear (cfg_clear),
    .sts       (sts),
    .cmd       (cmd)
  );

  swg_dp #(
    .MAX_ARMS     (MAX_ARMS),
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .REWARD_BITS  (REWARD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_command      (in_command),
    .in_reward       (in_reward),
    .in_arm          (in_arm),
    .in_rand_uniform (in_rand_uniform),
    .in_rand_arm     (in_rand_arm),
    .out_chosen_arm  (out_chosen_arm),
    .out_arm_sum     (out_arm_sum),
    .out_arm_hits    (out_arm_hits),
    .out_explored    (out_explored)
  );

  // An explored select result never carries statistics.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_explored |-> out_arm_sum == '0 && out_arm_hits == '0)
    else $error("explored select carries statistics");

  // No input transfer while a result waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  // A held result does not change.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid && out_stall) && out_valid |-> $stable(out_chosen_arm))
    else $error("stalled result changed");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the epsilon-greedy arm selector
// A queue-fed driver offers commands, an in-bench model of the reward window
// predicts each select and query result, and a monitor compares every result
// transfer in order, under several register settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module testbench;
  import swg_pkg::*;

  localparam int NARMS     = MAX_ARMS_DEF;
  localparam int DEPTH     = WINDOW_DEPTH_DEF;
  localparam int RBITS     = REWARD_BITS_DEF;
  localparam int MAX_CYCLE = 600000;

  typedef struct {
    cmd_t              cmd;
    logic [RBITS-1:0]  reward;
    logic [ARM_W-1:0]  arm;
    logic [RAND_W-1:0] rand_u;
    logic [ARM_W-1:0]  rand_a;
  } bandit_cmd_t;

  typedef struct {
    logic [ARM_W-1:0]  chosen;
    logic [SUM_W-1:0]  sum;
    logic [HITS_W-1:0] hits;
    logic              explored;
  } bandit_res_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic in_valid, in_stall;
  logic [1:0] in_command;
  logic [RBITS-1:0] in_reward;
  logic [ARM_W-1:0] in_arm, in_rand_arm;
  logic [RAND_W-1:0] in_rand_uniform;
  logic out_valid, out_stall;
  logic [ARM_W-1:0] out_chosen_arm;
  logic [SUM_W-1:0] out_arm_sum;
  logic [HITS_W-1:0] out_arm_hits;
  logic out_explored;

  sliding_window_epsilon_greedy_unit dut (.*);

  bandit_cmd_t pending_cmds[$];
  bandit_res_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_trigger = 0;

  // Model state of the window and the per-arm statistics.
  logic [EPS_W-1:0]  m_eps;
  logic [ARMC_W-1:0] m_armc;
  logic [WLEN_W-1:0] m_wlen;
  logic [RBITS-1:0]  win_reward[DEPTH];
  logic [ARM_W-1:0]  win_arm[DEPTH];
  int                win_head, win_fill, warm_idx;
  logic [SUM_W-1:0]  arm_sum_m[NARMS];
  logic [HITS_W-1:0] arm_cnt_m[NARMS];

  function automatic int arms_active();
    if (m_armc == 0) return 1;
    if (m_armc > NARMS) return NARMS;
    return m_armc;
  endfunction

  function automatic int window_cap();
    if (m_wlen == 0) return 1;
    if (m_wlen > DEPTH) return DEPTH;
    return m_wlen;
  endfunction

  task automatic clear_model();
    for (int i = 0; i < NARMS; i++) begin
      arm_sum_m[i] = '0;
      arm_cnt_m[i] = '0;
    end
    win_head = 0;
    win_fill = 0;
    warm_idx = 0;
  endtask

  function automatic int greedy_arm();
    int best;
    longint cb, ci;
    best = 0;
    for (int i = 1; i < arms_active(); i++) begin
      cb = (arm_cnt_m[best] != 0) ? arm_cnt_m[best] : 1;
      ci = (arm_cnt_m[i] != 0) ? arm_cnt_m[i] : 1;
      if (longint'(arm_sum_m[i]) * cb > longint'(arm_sum_m[best]) * ci) best = i;
    end
    return best;
  endfunction

  task automatic apply_cmd(input bandit_cmd_t c);
    bandit_res_t r;
    int n, old;
    n = arms_active();
    r = '{default: '0};
    case (c.cmd)
      CMD_UPDATE: begin
        if (c.arm < n) begin
          if (win_fill >= window_cap()) begin
            old = (win_head + DEPTH - win_fill) % DEPTH;
            if (arm_sum_m[win_arm[old]] >= win_reward[old])
              arm_sum_m[win_arm[old]] -= win_reward[old];
            else
              arm_sum_m[win_arm[old]] = '0;
            if (arm_cnt_m[win_arm[old]] > 0) arm_cnt_m[win_arm[old]]--;
            win_fill--;
          end
          win_reward[win_head] = c.reward;
          win_arm[win_head] = c.arm;
          win_head = (win_head + 1) % DEPTH;
          win_fill++;
          arm_sum_m[c.arm] += SUM_W'(c.reward);
          arm_cnt_m[c.arm]++;
        end
      end
      CMD_CLEAR: clear_model();
      CMD_SELECT: begin
        if (warm_idx < n) begin
          r.chosen = ARM_W'(warm_idx);
          warm_idx++;
        end else if (c.rand_u < m_eps) begin
          r.chosen = (c.rand_a < n) ? c.rand_a : ARM_W'(n - 1);
          r.explored = 1'b1;
        end else begin
          r.chosen = ARM_W'(greedy_arm());
        end
        expected_results = {expected_results, r};
      end
      default: begin
        r.sum = arm_sum_m[c.arm];
        r.hits = arm_cnt_m[c.arm];
        expected_results = {expected_results, r};
      end
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Driver: a new item is presented only when the slot is free.
  always @(posedge clk) begin
    bandit_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        apply_cmd('{cmd_t'(in_command), in_reward, in_arm, in_rand_uniform, in_rand_arm});
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          c = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_command <= c.cmd;
          in_reward <= c.reward;
          in_arm <= c.arm;
          in_rand_uniform <= c.rand_u;
          in_rand_arm <= c.rand_a;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, counted in cycles on its own.
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= 400;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each result transfer and drives the stall.
  always @(posedge clk) begin
    bandit_res_t e;
    if (out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer, arm %0d", out_chosen_arm);
      end else begin
        e = expected_results.pop_front();
        if (out_chosen_arm !== e.chosen || out_arm_sum !== e.sum ||
            out_arm_hits !== e.hits || out_explored !== e.explored) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp arm %0d sum %0d hits %0d expl %0d, got %0d %0d %0d %0d",
                     e.chosen, e.sum, e.hits, e.explored,
                     out_chosen_arm, out_arm_sum, out_arm_hits, out_explored);
        end
      end
    end
    if (hold_trigger != hold_seen || hold_left > 1) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    case (idx)
      CFG_EPSILON: m_eps = EPS_W'(value);
      CFG_ARM_COUNT: begin m_armc = ARMC_W'(value); clear_model(); end
      default: begin m_wlen = WLEN_W'(value); clear_model(); end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (20) @(posedge clk);
  endtask

  task automatic add_cmd(input cmd_t cmd, input int reward, input int arm,
                         input int ru, input int ra);
    bandit_cmd_t c;
    c = '{cmd, RBITS'(reward), ARM_W'(arm), RAND_W'(ru), ARM_W'(ra)};
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic add_random(input int count);
    int w, a;
    cmd_t c;
    for (int i = 0; i < count; i++) begin
      w = $urandom_range(99);
      c = (w < 45) ? CMD_UPDATE : (w < 80) ? CMD_SELECT : (w < 97) ? CMD_QUERY : CMD_CLEAR;
      a = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(arms_active() - 1);
      add_cmd(c, $urandom_range(65535), a, $urandom_range(65535), $urandom_range(15));
    end
  endtask

  // Waits until every item went in and every result came out, then lets an
  // item with no result finish.
  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_command = '0;
    in_reward = '0;
    in_arm = '0;
    in_rand_uniform = '0;
    in_rand_arm = '0;
    m_eps = EPS_RST;
    m_armc = ARMC_RST;
    m_wlen = WLEN_RST;
    clear_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: defaults, then three arms with edge values.
    add_cmd(CMD_QUERY, 0, 15, 0, 0);
    add_cmd(CMD_SELECT, 65535, 15, 65535, 15);
    drain();
    write_reg(CFG_ARM_COUNT, 3);
    add_cmd(CMD_UPDATE, 65535, 2, 65535, 15);
    add_cmd(CMD_UPDATE, 0, 0, 0, 0);
    add_cmd(CMD_UPDATE, 100, 1, 0, 0);
    add_cmd(CMD_UPDATE, 5, 7, 0, 0);      // arm not in use, ignored
    add_cmd(CMD_QUERY, 0, 2, 0, 0);
    add_cmd(CMD_QUERY, 0, 7, 0, 0);
    add_cmd(CMD_SELECT, 0, 0, 0, 0);
    add_cmd(CMD_SELECT, 0, 0, 0, 0);
    add_cmd(CMD_SELECT, 0, 0, 0, 0);
    add_cmd(CMD_SELECT, 0, 0, 0, 15);     // explore with clamped arm
    add_cmd(CMD_SELECT, 0, 0, 65535, 0);  // exploit
    add_cmd(CMD_CLEAR, 0, 0, 0, 0);
    add_cmd(CMD_QUERY, 0, 2, 0, 0);
    add_cmd(CMD_SELECT, 65535, 15, 65535, 15);
    drain();

    send_idle_pct = 48;
    write_reg(CFG_EPSILON, 0);
    write_reg(CFG_ARM_COUNT, 1);
    write_reg(CFG_WIN_LEN, 1);
    add_random(100);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 48;
    write_reg(CFG_EPSILON, 65536);
    write_reg(CFG_ARM_COUNT, 16);
    write_reg(CFG_WIN_LEN, 64);
    hold_trigger = 1;
    add_random(120);
    drain();

    send_idle_pct = 24;
    recv_stall_pct = 24;
    write_reg(CFG_EPSILON, 0);
    add_random(150);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CFG_EPSILON, $urandom_range(65535));
    write_reg(CFG_ARM_COUNT, 5);
    write_reg(CFG_WIN_LEN, 7);
    add_random(120);
    drain();

    // Out-of-range register values.
    recv_stall_pct = 24;
    write_reg(CFG_EPSILON, 131071);
    write_reg(CFG_ARM_COUNT, 0);
    write_reg(CFG_WIN_LEN, 0);
    add_random(30);
    drain();
    write_reg(CFG_EPSILON, 20000);
    write_reg(CFG_ARM_COUNT, 31);
    write_reg(CFG_WIN_LEN, 127);
    add_random(60);
    drain();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/swg_pkg.sv
rtl/swg_ram.sv
rtl/swg_ctrl.sv
rtl/swg_dp.sv
rtl/sliding_window_epsilon_greedy_unit.sv
dv/testbench.sv
